@@ src/psc_pkg.sv @@
// ---------------------------------------------------------------------------
// psc_pkg
// Shared constants for the parabolic sine and cosine pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

    // default field formats
    localparam int ANGLE_WIDTH_DEF      = 32;
    localparam int RESULT_FRAC_BITS_DEF = 16;

    // internal fraction bits of the polynomial path
    localparam int FRAC_Q = 30;

    // 1/(2*pi) with 48 fraction bits, split for two narrow multipliers
    localparam logic [45:0] INV_TWO_PI_Q48 = 46'h28BE60DB9391;
    localparam logic [21:0] INV_TWO_PI_HI  = INV_TWO_PI_Q48[45:24];
    localparam logic [23:0] INV_TWO_PI_LO  = INV_TWO_PI_Q48[23:0];
    localparam int          INV_LO_BITS    = 24;

    // 0.2215 with 30 fraction bits, and one in the same format
    localparam logic [27:0]        CORR_Q30 = 28'd237833814;
    localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

    // quarter turn on the 32-bit phase
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // register stages: two for the phase, the rest for the polynomial
    localparam int EVAL_STAGES = 6;
    localparam int PIPE_DEPTH  = EVAL_STAGES + 2;

endpackage

`default_nettype wire

@@ src/psc_if.sv @@
// ---------------------------------------------------------------------------
// psc_angle_if / psc_result_if
// Valid/ready channels for angle requests and sine/cosine results.
// ---------------------------------------------------------------------------
`default_nettype none

interface psc_angle_if import psc_pkg::*; #(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface psc_result_if import psc_pkg::*; #(
    parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic signed [RESULT_FRAC_BITS+1:0] sine;
    logic signed [RESULT_FRAC_BITS+1:0] cosine;

    modport source (output valid, output sine, output cosine, input ready);
    modport sink   (input valid, input sine, input cosine, output ready);
endinterface

`default_nettype wire

@@ src/psc_eval.sv @@
// ---------------------------------------------------------------------------
// psc_eval
// Six-stage datapath: parabola, correction, clamp and output scaling of one
// signed half-turn phase.
// ---------------------------------------------------------------------------
`default_nettype none

module psc_eval import psc_pkg::*; #(
    parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic [EVAL_STAGES-1:0]             en,
    input  wire logic signed [31:0]                 t,
    output logic signed [RESULT_FRAC_BITS+1:0]      r
);

    localparam int RW = RESULT_FRAC_BITS + 2;

    // stage 0: t * |t|
    logic        [31:0]        mag_t;
    logic signed [64:0]        tt_full;
    logic signed [31:0]        t_reg;
    logic signed [63:0]        tt_reg;

    // stage 1: y = 2t - t|t|
    logic signed [34:0]        y_full;
    logic signed [31:0]        y_reg;

    // stage 2: y * |y|
    logic        [30:0]        mag_y;
    logic signed [63:0]        yy_full;
    logic signed [63:0]        yy_reg;
    logic signed [31:0]        y2_reg;

    // stage 3: d = y|y| - y
    logic signed [34:0]        d_full;
    logic signed [31:0]        d_reg;
    logic signed [31:0]        y3_reg;

    // stage 4: 0.2215 * d
    logic signed [60:0]        cd_full;
    logic signed [60:0]        cd_reg;
    logic signed [31:0]        y4_reg;

    // stage 5: z, clamp and scale
    logic signed [33:0]        z;
    logic signed [31:0]        zc;
    logic signed [RW-1:0]      r_reg;

    // magnitude and square of the phase
    always_comb
    begin
        mag_t   = t[31] ? 32'(-t) : 32'(t);
        tt_full = t * $signed({1'b0, mag_t});
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t_reg  <= t;
            tt_reg <= tt_full[63:0];
        end
    end

    // parabola
    always_comb
    begin
        y_full = (35'(t_reg) <<< 1) - 35'(tt_reg >>> FRAC_Q);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            y_reg <= y_full[31:0];
        end
    end

    // square of the parabola
    always_comb
    begin
        mag_y   = y_reg[31] ? 31'(-y_reg) : 31'(y_reg);
        yy_full = y_reg * $signed({1'b0, mag_y});
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            yy_reg <= yy_full;
            y2_reg <= y_reg;
        end
    end

    // correction term
    always_comb
    begin
        d_full = 35'(yy_reg >>> FRAC_Q) - 35'(y2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            d_reg  <= d_full[31:0];
            y3_reg <= y2_reg;
        end
    end

    // weight of the correction
    always_comb
    begin
        cd_full = $signed({1'b0, CORR_Q30}) * d_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            cd_reg <= cd_full;
            y4_reg <= y3_reg;
        end
    end

    // sum, clamp to [-1, 1] and drop extra fraction bits
    always_comb
    begin
        z = 34'(cd_reg >>> FRAC_Q) + 34'(y4_reg);
        priority if (z > ONE_Q30)
        begin
            zc = 32'(ONE_Q30);
        end
        else if (z < -ONE_Q30)
        begin
            zc = 32'(-ONE_Q30);
        end
        else
        begin
            zc = 32'(z);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            r_reg <= RW'(zc >>> (FRAC_Q - RESULT_FRAC_BITS));
        end
    end

    assign r = r_reg;

endmodule

`default_nettype wire

@@ src/parabolic_sine_cosine.sv @@
// ---------------------------------------------------------------------------
// parabolic_sine_cosine
// Parabolic sine and cosine of a signed 16.16 angle in radians.
// ---------------------------------------------------------------------------
//
//  channel  modport  payload                        meaning
//  -------  -------  -----------------------------  -------------------------
//  angle    sink     angle  (ANGLE_WIDTH, signed)   angle request, 16.16 rad
//  result   source   sine, cosine (RFB+2, signed)   results, RFB fraction bits
//
//  One request per clock cycle sustained while results are taken; two
//  register stages form the phase (partial products, then their sum) and
//  six evaluate it (t|t|, y, y|y|, d, correction weight, clamp and scale).
//  Reset clears only the stage valid bits; no clearing pass.
//  A stalled result holds in the output register; earlier stages keep
//  filling bubbles, so requests are taken until every stage holds an item.
//
`default_nettype none

module parabolic_sine_cosine import psc_pkg::*; #(
    parameter int ANGLE_WIDTH      = ANGLE_WIDTH_DEF,
    parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    psc_angle_if.sink     angle,
    psc_result_if.source  result
);

    localparam int PH_W = ANGLE_WIDTH + 23;
    localparam int PL_W = ANGLE_WIDTH + 25;

    logic [PIPE_DEPTH-1:0]   valid_reg;
    logic [PIPE_DEPTH-1:0]   en;

    logic signed [PH_W-1:0]  pp_hi_reg;
    logic signed [PL_W-1:0]  pp_lo_reg;
    logic        [63:0]      phase_sum;
    logic        [31:0]      sin_t_reg;
    logic        [31:0]      cos_t_reg;

    // stage enables: a stage loads when empty or when the next one loads
    always_comb
    begin
        en[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || result.ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= angle.valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // partial products of angle and 1/(2*pi)
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pp_hi_reg <= angle.angle * $signed({1'b0, INV_TWO_PI_HI});
            pp_lo_reg <= angle.angle * $signed({1'b0, INV_TWO_PI_LO});
        end
    end

    // phase in turns, modulo one turn, and the quarter-turn shift
    always_comb
    begin
        phase_sum = (64'(pp_hi_reg) <<< INV_LO_BITS) + 64'(pp_lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sin_t_reg <= phase_sum[63:32];
            cos_t_reg <= phase_sum[63:32] + QUARTER_TURN;
        end
    end

    // polynomial paths
    psc_eval #(
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_sine (
        .clk (clk),
        .en  (en[PIPE_DEPTH-1:2]),
        .t   ($signed(sin_t_reg)),
        .r   (result.sine)
    );

    psc_eval #(
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_cosine (
        .clk (clk),
        .en  (en[PIPE_DEPTH-1:2]),
        .t   ($signed(cos_t_reg)),
        .r   (result.cosine)
    );

    assign angle.ready  = en[0];
    assign result.valid = valid_reg[PIPE_DEPTH-1];

endmodule

`default_nettype wire

@@ src/psc_checker.sv @@
// ---------------------------------------------------------------------------
// psc_checker
// Port-level checks of the sine/cosine pipeline, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module psc_checker import psc_pkg::*; #(
    parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_ready,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic signed [RESULT_FRAC_BITS+1:0] sine,
    input wire logic signed [RESULT_FRAC_BITS+1:0] cosine
);

    localparam int RW  = RESULT_FRAC_BITS + 2;
    localparam int CW  = $clog2(PIPE_DEPTH + 1);
    localparam logic signed [RW-1:0] ONE_OUT = RW'(1) <<< RESULT_FRAC_BITS;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // requests in flight
    always_comb
    begin
        count_next = count_reg;
        if (in_valid && in_ready)
        begin
            count_next = count_next + CW'(1);
        end
        if (out_valid && out_ready)
        begin
            count_next = count_next - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sine) && $stable(cosine))
        else $error("stalled result changed");

    // results stay within [-1, 1]
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sine >= -ONE_OUT && sine <= ONE_OUT
                      && cosine >= -ONE_OUT && cosine <= ONE_OUT)
        else $error("result out of range");

    // requests are refused only when every stage is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready && count_reg == CW'(PIPE_DEPTH))
        else $error("request refused with room in the pipeline");

    // no result without a request, never more in flight than stages
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || count_reg != '0) && count_reg <= CW'(PIPE_DEPTH))
        else $error("in-flight count inconsistent");

endmodule

bind parabolic_sine_cosine psc_checker #(
    .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
) u_psc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (angle.valid),
    .in_ready  (angle.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sine      (result.sine),
    .cosine    (result.cosine)
);

`default_nettype wire
